// ----- rtl/core/uhist_pkg.sv -----
// Shared types, constants and control structs for the uniform-bin histogram.
package uhist_pkg;

  // Default sizing
  localparam int MAX_BINS_DEF    = 1024;
  localparam int COUNT_WIDTH_DEF = 32;

  // Fixed field widths
  localparam int NB_W     = 11;  // num_bins / active bin count
  localparam int BW_W     = 31;  // bin_width
  localparam int IDX_W    = 10;  // bin index on the ports
  localparam int SAMPLE_W = 32;
  localparam int OUT_W    = 32;  // reported counter width
  localparam int PADDR_W  = 3;
  localparam int PDATA_W  = 32;

  localparam int RESET_NUM_BINS  = 1024;
  localparam int RESET_BIN_WIDTH = 65536;

  // Register indexes (paddr[2])
  localparam logic REG_NUM_BINS  = 1'b0;
  localparam logic REG_BIN_WIDTH = 1'b1;

  typedef enum logic [1:0] {
    FN_ADD   = 2'd0,
    FN_READ  = 2'd1,
    FN_TRUNC = 2'd2,
    FN_NOP   = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_UNDER = 2'd1,
    ST_OVER  = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_DIV,
    S_ADD_WR,
    S_READ_CAP,
    S_SCAN,
    S_EMIT
  } state_t;

  // Controller -> datapath
  typedef struct packed {
    logic clr_wr;
    logic accept;
    logic under;
    logic div_start;
    logic over;
    logic add_rd;
    logic add_wr;
    logic rd_issue;
    logic rd_cap;
    logic scan_init;
    logic scan_step;
    logic scan_fin;
    logic nop_res;
    logic emit;
  } cmd_t;

  // Datapath -> controller
  typedef struct packed {
    func_t func;
    logic  neg;
    logic  div_done;
    logic  div_over;
    logic  scan_done;
    logic  clr_last;
    logic  out_free;
  } sts_t;

endpackage

// ----- rtl/core/uniform_bin_histogram.sv -----
// Uniform-bin histogram: top level with register port, controller and datapath.
// Add: 31-step radix-2 divider, then a read-modify-write of the bin store (skipped
//   above range). Read: one bin store read; no-op, negative sample: none. Truncate:
//   one bin store read per cycle over the active bins. A new beat is taken only once
//   the last result is in the output register, where it waits until taken.
// Sync reset clears counters, then a pass over all bins zeroes them (in_ready low).
module uniform_bin_histogram import uhist_pkg::*; #(
  parameter int MAX_BINS    = MAX_BINS_DEF,
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  // Register port
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [PADDR_W-1:0]         paddr,
  input  logic [PDATA_W-1:0]         pwdata,
  output logic [PDATA_W-1:0]         prdata,
  output logic                       pready,
  // Input beats
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [1:0]                 in_func,
  input  logic signed [SAMPLE_W-1:0] in_sample,
  input  logic [IDX_W-1:0]           in_bin_select,
  // Result beats
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [1:0]                 out_status,
  output logic [IDX_W-1:0]           out_bin_index,
  output logic [OUT_W-1:0]           out_bin_count,
  output logic [OUT_W-1:0]           out_total_count,
  output logic [OUT_W-1:0]           out_underflow_count,
  output logic [OUT_W-1:0]           out_overflow_count,
  output logic [NB_W-1:0]            out_active_bins
);

  // Register file: num_bins at 0x0, bin_width at 0x4
  logic [NB_W-1:0] num_bins_r;
  logic [BW_W-1:0] bin_width_r;
  logic            reg_wr;
  logic            reg_idx;
  logic            nb_wr;

  cmd_t cmd;
  sts_t sts;

  assign pready  = 1'b1;
  assign reg_idx = paddr[2];
  assign reg_wr  = psel && penable && pwrite;
  assign nb_wr   = reg_wr && (reg_idx == REG_NUM_BINS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_bins_r  <= NB_W'(RESET_NUM_BINS);
      bin_width_r <= BW_W'(RESET_BIN_WIDTH);
    end else if (reg_wr) begin
      if (reg_idx == REG_NUM_BINS) begin
        num_bins_r <= pwdata[NB_W-1:0];
      end else begin
        bin_width_r <= pwdata[BW_W-1:0];
      end
    end
  end

  // Readback of the raw register values
  always_comb begin
    if (reg_idx == REG_BIN_WIDTH) begin
      prdata = PDATA_W'(bin_width_r);
    end else begin
      prdata = PDATA_W'(num_bins_r);
    end
  end

  uhist_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Writing num_bins also reloads the active bin count in the datapath
  uhist_dp #(
    .MAX_BINS    (MAX_BINS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .sts                 (sts),
    .in_func             (in_func),
    .in_sample           (in_sample),
    .in_bin_select       (in_bin_select),
    .bin_width           (bin_width_r),
    .nb_wr               (nb_wr),
    .nb_val              (pwdata[NB_W-1:0]),
    .out_ready           (out_ready),
    .out_valid           (out_valid),
    .out_status          (out_status),
    .out_bin_index       (out_bin_index),
    .out_bin_count       (out_bin_count),
    .out_total_count     (out_total_count),
    .out_underflow_count (out_underflow_count),
    .out_overflow_count  (out_overflow_count),
    .out_active_bins     (out_active_bins)
  );

endmodule

// ----- rtl/core/uhist_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module uhist_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/core/uhist_div.sv -----
// Restoring radix-2 divider, one quotient bit per cycle.
module uhist_div #(
  parameter int W = 31
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         done,
  output logic [W-1:0] quotient,
  output logic [W-1:0] remainder
);

  localparam int CNT_W = $clog2(W + 1);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [W-1:0]     quo_r;
  logic [W-1:0]     rem_r;
  logic [W-1:0]     dvs_r;

  logic [W:0]       shifted;
  logic [W:0]       diff;
  logic             ge;
  logic [W-1:0]     rem_nxt;
  logic [W-1:0]     quo_nxt;

  always_comb begin
    shifted = {rem_r, quo_r[W-1]};
    diff    = shifted - {1'b0, dvs_r};
    ge      = (shifted >= {1'b0, dvs_r});
    rem_nxt = ge ? diff[W-1:0] : shifted[W-1:0];
    quo_nxt = {quo_r[W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

// ----- rtl/core/uhist_dp.sv -----
// Histogram datapath: bin store, divider, counters, scan logic, output register.
module uhist_dp import uhist_pkg::*; #(
  parameter int MAX_BINS    = MAX_BINS_DEF,
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  cmd_t                cmd,
  output sts_t                sts,
  input  logic [1:0]          in_func,
  input  logic [SAMPLE_W-1:0] in_sample,
  input  logic [IDX_W-1:0]    in_bin_select,
  input  logic [BW_W-1:0]     bin_width,
  input  logic                nb_wr,
  input  logic [NB_W-1:0]     nb_val,
  input  logic                out_ready,
  output logic                out_valid,
  output logic [1:0]          out_status,
  output logic [IDX_W-1:0]    out_bin_index,
  output logic [OUT_W-1:0]    out_bin_count,
  output logic [OUT_W-1:0]    out_total_count,
  output logic [OUT_W-1:0]    out_underflow_count,
  output logic [OUT_W-1:0]    out_overflow_count,
  output logic [NB_W-1:0]     out_active_bins
);

  localparam int AW = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
  localparam int CW = COUNT_WIDTH;
  localparam logic [CW-1:0] CNT_MAX = '1;
  localparam logic [NB_W-1:0] BIU_RST = (RESET_NUM_BINS > MAX_BINS) ?
                                        NB_W'(MAX_BINS) : NB_W'(RESET_NUM_BINS);

  function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] v);
    return (v == CNT_MAX) ? v : v + CW'(1);
  endfunction

  function automatic logic [NB_W-1:0] clamp_bins(input logic [NB_W-1:0] n);
    logic [NB_W-1:0] r;
    r = n;
    if (n == '0) begin
      r = NB_W'(1);
    end else if (32'(n) > 32'(MAX_BINS)) begin
      r = NB_W'(MAX_BINS);
    end
    return r;
  endfunction

  // Latched item
  func_t                func_r;
  logic [SAMPLE_W-1:0]  sample_r;
  logic [IDX_W-1:0]     sel_r;

  // Histogram state
  logic [NB_W-1:0]      biu_r;
  logic [CW-1:0]        total_r;
  logic [CW-1:0]        below_r;
  logic [CW-1:0]        above_r;

  logic [AW-1:0]        clr_addr_r;
  logic [NB_W-1:0]      add_idx_r;

  // Truncate scan
  logic [NB_W-1:0]      scan_idx_r;
  logic                 chk_r;
  logic [NB_W-1:0]      chk_tag_r;
  logic [NB_W-1:0]      top_r;
  logic [CW-1:0]        top_cnt_r;

  // Pending result
  status_t              res_status_r;
  logic [IDX_W-1:0]     res_idx_r;
  logic [CW-1:0]        res_cnt_r;

  // Output register
  logic                 out_valid_r;
  logic [1:0]           out_status_r;
  logic [IDX_W-1:0]     out_idx_r;
  logic [OUT_W-1:0]     out_cnt_r;
  logic [OUT_W-1:0]     out_total_r;
  logic [OUT_W-1:0]     out_below_r;
  logic [OUT_W-1:0]     out_above_r;
  logic [NB_W-1:0]      out_biu_r;

  logic [BW_W-1:0]      w_eff;
  logic                 div_done;
  logic [BW_W-1:0]      quo;
  logic [BW_W-1:0]      rem;
  logic                 q_ge;
  logic                 q_eq;
  logic                 over;
  logic [NB_W-1:0]      idx_sel;
  logic                 scan_issue;
  logic                 sel_ok;

  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [CW-1:0]        ram_wdata;
  logic [AW-1:0]        ram_raddr;
  logic [CW-1:0]        ram_rdata;

  assign w_eff = (bin_width == '0) ? BW_W'(1) : bin_width;

  uhist_div #(.W(BW_W)) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (cmd.div_start),
    .dividend  (sample_r[BW_W-1:0]),
    .divisor   (w_eff),
    .done      (div_done),
    .quotient  (quo),
    .remainder (rem)
  );

  // sample <= w*biu  <=>  q < biu, or q == biu with no remainder
  always_comb begin
    q_ge    = (quo >= BW_W'(biu_r));
    q_eq    = (quo == BW_W'(biu_r));
    over    = (q_ge && !q_eq) || (q_eq && (rem != '0));
    idx_sel = q_ge ? (biu_r - NB_W'(1)) : NB_W'(quo);
  end

  assign scan_issue = cmd.scan_step && (scan_idx_r != biu_r);
  assign sel_ok     = (32'(sel_r) < 32'(MAX_BINS));

  always_comb begin
    ram_we    = cmd.clr_wr || cmd.add_wr;
    ram_waddr = cmd.clr_wr ? clr_addr_r : AW'(add_idx_r);
    ram_wdata = cmd.clr_wr ? '0 : sat_inc(ram_rdata);
    priority if (cmd.rd_issue) begin
      ram_raddr = AW'(sel_r);
    end else if (cmd.add_rd) begin
      ram_raddr = AW'(idx_sel);
    end else begin
      ram_raddr = AW'(scan_idx_r);
    end
  end

  uhist_ram #(.WIDTH(CW), .DEPTH(MAX_BINS)) u_bins (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Control-side state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      biu_r       <= BIU_RST;
      total_r     <= '0;
      below_r     <= '0;
      above_r     <= '0;
      clr_addr_r  <= '0;
      chk_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clr_wr) begin
        clr_addr_r <= clr_addr_r + AW'(1);
      end
      if (cmd.under) begin
        below_r <= sat_inc(below_r);
      end
      if (cmd.over) begin
        above_r <= sat_inc(above_r);
      end
      if (cmd.add_wr) begin
        total_r <= sat_inc(total_r);
      end
      if (nb_wr) begin
        biu_r <= clamp_bins(nb_val);
      end else if (cmd.scan_fin) begin
        biu_r <= top_r + NB_W'(1);
      end
      if (cmd.scan_init) begin
        chk_r <= 1'b0;
      end else begin
        chk_r <= scan_issue;
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      func_r   <= func_t'(in_func);
      sample_r <= in_sample;
      sel_r    <= in_bin_select;
    end
    if (cmd.add_rd) begin
      add_idx_r <= idx_sel;
    end
    if (cmd.scan_init) begin
      scan_idx_r <= '0;
      top_r      <= '0;
      top_cnt_r  <= '0;
    end else begin
      if (scan_issue) begin
        scan_idx_r <= scan_idx_r + NB_W'(1);
      end
      chk_tag_r <= scan_idx_r;
      if (chk_r && (ram_rdata != '0)) begin
        top_r     <= chk_tag_r;
        top_cnt_r <= ram_rdata;
      end
    end
    // one result command per item, the rest of the time the result holds
    if (cmd.under) begin
      res_status_r <= ST_UNDER;
      res_idx_r    <= '0;
      res_cnt_r    <= '0;
    end else if (cmd.over) begin
      res_status_r <= ST_OVER;
      res_idx_r    <= '0;
      res_cnt_r    <= '0;
    end else if (cmd.add_wr) begin
      res_status_r <= ST_OK;
      res_idx_r    <= IDX_W'(add_idx_r);
      res_cnt_r    <= sat_inc(ram_rdata);
    end else if (cmd.rd_cap) begin
      res_status_r <= ST_OK;
      res_idx_r    <= sel_r;
      res_cnt_r    <= sel_ok ? ram_rdata : '0;
    end else if (cmd.scan_fin) begin
      res_status_r <= ST_OK;
      res_idx_r    <= IDX_W'(top_r);
      res_cnt_r    <= top_cnt_r;
    end else if (cmd.nop_res) begin
      res_status_r <= ST_OK;
      res_idx_r    <= '0;
      res_cnt_r    <= '0;
    end
    if (cmd.emit) begin
      out_status_r <= res_status_r;
      out_idx_r    <= res_idx_r;
      out_cnt_r    <= OUT_W'(res_cnt_r);
      out_total_r  <= OUT_W'(total_r);
      out_below_r  <= OUT_W'(below_r);
      out_above_r  <= OUT_W'(above_r);
      out_biu_r    <= biu_r;
    end
  end

  always_comb begin
    sts.func      = func_r;
    sts.neg       = sample_r[SAMPLE_W-1];
    sts.div_done  = div_done;
    sts.div_over  = over;
    sts.scan_done = (scan_idx_r == biu_r) && !chk_r;
    sts.clr_last  = (clr_addr_r == AW'(MAX_BINS - 1));
    sts.out_free  = !out_valid_r || out_ready;
  end

  assign out_valid           = out_valid_r;
  assign out_status          = out_status_r;
  assign out_bin_index       = out_idx_r;
  assign out_bin_count       = out_cnt_r;
  assign out_total_count     = out_total_r;
  assign out_underflow_count = out_below_r;
  assign out_overflow_count  = out_above_r;
  assign out_active_bins     = out_biu_r;

endmodule

// ----- rtl/core/uhist_ctrl.sv -----
// Histogram controller: sequences clear, add, read, truncate and no-op operations.
module uhist_ctrl import uhist_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (sts.func)
          FN_ADD: begin
            if (sts.neg) begin
              cmd.under = 1'b1;
              state_nxt = S_EMIT;
            end else begin
              cmd.div_start = 1'b1;
              state_nxt     = S_DIV;
            end
          end
          FN_READ: begin
            cmd.rd_issue = 1'b1;
            state_nxt    = S_READ_CAP;
          end
          FN_TRUNC: begin
            cmd.scan_init = 1'b1;
            state_nxt     = S_SCAN;
          end
          FN_NOP: begin
            cmd.nop_res = 1'b1;
            state_nxt   = S_EMIT;
          end
          default: begin
            cmd.nop_res = 1'b1;
            state_nxt   = S_EMIT;
          end
        endcase
      end
      S_DIV: begin
        if (sts.div_done) begin
          if (sts.div_over) begin
            cmd.over  = 1'b1;
            state_nxt = S_EMIT;
          end else begin
            cmd.add_rd = 1'b1;
            state_nxt  = S_ADD_WR;
          end
        end
      end
      S_ADD_WR: begin
        cmd.add_wr = 1'b1;
        state_nxt  = S_EMIT;
      end
      S_READ_CAP: begin
        cmd.rd_cap = 1'b1;
        state_nxt  = S_EMIT;
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_done) begin
          cmd.scan_fin = 1'b1;
          state_nxt    = S_EMIT;
        end
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/core/uhist_chk.sv -----
// Port-level checker for the histogram, bound to the top level.
module uhist_chk import uhist_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_ready,
  input logic [1:0]        out_status,
  input logic [IDX_W-1:0]  out_bin_index,
  input logic [OUT_W-1:0]  out_bin_count,
  input logic [OUT_W-1:0]  out_total_count,
  input logic [OUT_W-1:0]  out_underflow_count
);

  logic             seen_r;
  logic [OUT_W-1:0] last_total_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r       <= 1'b0;
      last_total_r <= '0;
    end else if (out_valid && out_ready) begin
      seen_r       <= 1'b1;
      last_total_r <= out_total_count;
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_total_count) &&
                               $stable(out_bin_count) && $stable(out_status))
    else $error("result beat changed while stalled");

  a_range_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_UNDER || out_status == ST_OVER) |->
      out_bin_index == '0 && out_bin_count == '0)
    else $error("out-of-range sample reported a bin");

  a_under_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_UNDER |-> out_underflow_count != '0)
    else $error("underflow status with zero underflow count");

  a_total_mono: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && seen_r |-> out_total_count >= last_total_r)
    else $error("total count went down");

endmodule

bind uniform_bin_histogram uhist_chk u_uhist_chk (
  .clk                 (clk),
  .rst_n               (rst_n),
  .out_valid           (out_valid),
  .out_ready           (out_ready),
  .out_status          (out_status),
  .out_bin_index       (out_bin_index),
  .out_bin_count       (out_bin_count),
  .out_total_count     (out_total_count),
  .out_underflow_count (out_underflow_count)
);
